// ===== src/attack_release_envelope_gate_defines.svh =====
// Assertion macros shared by the envelope gate RTL.
// Each macro expands to one labeled concurrent assertion.
`ifndef ATTACK_RELEASE_ENVELOPE_GATE_DEFINES_SVH
`define ATTACK_RELEASE_ENVELOPE_GATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AREG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AREG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/areg_pkg.sv =====
// Shared types, constants and gate table builders for the envelope gate.
// No dependencies; imported by every module of the block.
package areg_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS       = 16;
    localparam int GATE_BITS       = 16;
    localparam int CHAN_BITS       = 2;
    localparam int CFG_IDX_BITS    = 2;
    localparam int GATE_IDX_BITS   = 10;
    localparam int GATE_SIZE       = (1 << GATE_IDX_BITS) + 1;
    localparam int EVEN_SIZE       = (GATE_SIZE + 1) / 2;
    localparam int ODD_SIZE        = GATE_SIZE / 2;
    localparam int EVEN_AW         = $clog2(EVEN_SIZE);
    localparam int ODD_AW          = $clog2(ODD_SIZE);

    localparam logic [COEF_BITS-1:0] ATTACK_RST  = 16'd64185;
    localparam logic [COEF_BITS-1:0] RELEASE_RST = 16'd65468;
    localparam logic [CHAN_BITS-1:0] CHAN_RST    = 2'd2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 2'd2;

    // channel count codes
    localparam logic [CHAN_BITS-1:0] CHAN_NONE = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_MONO = 2'd1;

    // e^(-28/1024) in Q0.32
    localparam logic [64:0] EXP_STEP_Q32 = 65'd4179117881;

    typedef struct packed {
        logic [COEF_BITS-1:0] attack_coeff;
        logic [COEF_BITS-1:0] release_coeff;
        logic [CHAN_BITS-1:0] channel_count;
    } t_cfg;

    typedef logic [GATE_BITS-1:0] t_gate_tab  [0:GATE_SIZE-1];
    typedef logic [GATE_BITS-1:0] t_gate_even [0:EVEN_SIZE-1];
    typedef logic [GATE_BITS-1:0] t_gate_odd  [0:ODD_SIZE-1];

    // shift-and-subtract quotient, used only while building the tables
    function automatic logic [64:0] f_udiv(logic [64:0] num, logic [64:0] den);
        logic [64:0] quo;
        logic [65:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 64; b >= 0; b--) begin
            rem = {rem[64:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(28*i/2048) in Q0.16, via u = e^(-2x) stepped in Q0.32
    function automatic t_gate_tab f_gate_tab();
        t_gate_tab   tab;
        logic [64:0] one;
        logic [64:0] u;
        logic [64:0] den;
        logic [64:0] g;
        one = 65'd1 << 32;
        u   = one;
        for (int i = 0; i < GATE_SIZE; i++) begin
            den    = one + u;
            g      = f_udiv(((one - u) << 16) + (den >> 1), den);
            tab[i] = (g > 65'd65535) ? {GATE_BITS{1'b1}} : g[GATE_BITS-1:0];
            u      = (u * EXP_STEP_Q32 + (65'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    function automatic t_gate_even f_gate_even();
        t_gate_tab  tab;
        t_gate_even ev;
        tab = f_gate_tab();
        for (int k = 0; k < EVEN_SIZE; k++) begin
            ev[k] = tab[2 * k];
        end
        return ev;
    endfunction

    function automatic t_gate_odd f_gate_odd();
        t_gate_tab tab;
        t_gate_odd od;
        tab = f_gate_tab();
        for (int k = 0; k < ODD_SIZE; k++) begin
            od[k] = tab[2 * k + 1];
        end
        return od;
    endfunction

endpackage

// ===== src/areg_lane.sv =====
// One channel lane: rectify a signed sample into a registered magnitude.
// Depends on areg_pkg.
module areg_lane
    import areg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic        [SAMPLE_BITS-1:0] o_mag
);

    logic [SAMPLE_BITS-1:0] n_mag;
    logic [SAMPLE_BITS-1:0] r_mag;

    // the most negative code maps to 2^(SAMPLE_BITS-1), still in range unsigned
    assign n_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

// ===== src/areg_merge.sv =====
// Merge stage: combines the lane magnitudes into one level per frame.
// Depends on areg_pkg.
module areg_merge
    import areg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [CHAN_BITS-1:0]   i_channel_count,
    input  logic [SAMPLE_BITS-1:0] i_mag_l,
    input  logic [SAMPLE_BITS-1:0] i_mag_r,
    output logic [SAMPLE_BITS-1:0] o_level
);

    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] n_level;
    logic [SAMPLE_BITS-1:0] r_level;

    assign sum = {1'b0, i_mag_l} + {1'b0, i_mag_r};

    always_comb begin
        case (i_channel_count)
            CHAN_NONE: n_level = '0;
            CHAN_MONO: n_level = i_mag_l;
            default:   n_level = sum[SAMPLE_BITS:1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// ===== src/areg_env.sv =====
// Envelope stage: one-pole attack/release smoother holding the envelope state.
// Depends on areg_pkg.
module areg_env
    import areg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_cfg                   i_cfg,
    input  logic [SAMPLE_BITS-1:0] i_level,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_env
);

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 2;

    logic                          r_valid;
    logic        [SAMPLE_BITS-1:0] r_env;
    logic        [SAMPLE_BITS-1:0] n_env;
    logic        [COEF_BITS-1:0]   coeff;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   step;

    // env' = level + round(c * (env - level) / 2^16), floor after adding half
    assign coeff = (i_level > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign diff  = $signed({1'b0, r_env}) - $signed({1'b0, i_level});
    assign prod  = PROD_BITS'($signed({1'b0, coeff}) * diff);
    assign step  = (prod + PROD_BITS'(32768)) >>> COEF_BITS;
    assign n_env = i_level + step[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_env   <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_env <= n_env;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_env   = r_env;

endmodule

// ===== src/areg_gate.sv =====
// Gate stage: banked tanh table read with registered data, then interpolation.
// Depends on areg_pkg for the table builders and index widths.
module areg_gate
    import areg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_env,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_env,
    output logic [GATE_BITS-1:0]   o_gate
);

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int FB        = (FRAC_BITS >= GATE_IDX_BITS) ? FRAC_BITS - GATE_IDX_BITS : 0;
    localparam int FW        = (FB > 0) ? FB : 1;
    localparam int IDX_BITS  = GATE_IDX_BITS + 1;

    localparam t_gate_even GATE_EVEN = f_gate_even();
    localparam t_gate_odd  GATE_ODD  = f_gate_odd();

    logic [IDX_BITS-1:0]      idx;
    logic [FW-1:0]            frac;
    logic [EVEN_AW-1:0]       half;
    logic [EVEN_AW-1:0]       even_addr;
    logic [ODD_AW-1:0]        odd_addr;
    logic                     sat;

    logic                     r_valid;
    logic [SAMPLE_BITS-1:0]   r_env;
    logic [GATE_BITS-1:0]     r_even_q;
    logic [GATE_BITS-1:0]     r_odd_q;
    logic                     r_odd_sel;
    logic                     r_sat;
    logic [FW-1:0]            r_frac;

    logic [GATE_BITS-1:0]     lo;
    logic [GATE_BITS-1:0]     hi;
    logic [GATE_BITS-1:0]     delta;
    logic [GATE_BITS+FW-1:0]  prod;

    generate
        if (FB > 0) begin : g_frac
            assign idx  = i_env[SAMPLE_BITS-1:FB];
            assign frac = i_env[FB-1:0];
        end else if (FRAC_BITS >= GATE_IDX_BITS) begin : g_exact
            assign idx  = i_env[IDX_BITS-1:0];
            assign frac = '0;
        end else begin : g_scale
            assign idx  = {i_env, {(GATE_IDX_BITS - FRAC_BITS){1'b0}}};
            assign frac = '0;
        end
    endgenerate

    // entries i and i+1 always sit in opposite banks
    assign sat       = idx[IDX_BITS-1];
    assign half      = idx[IDX_BITS-1:1];
    assign even_addr = sat ? EVEN_AW'(ODD_SIZE) : (idx[0] ? half + 1'b1 : half);
    assign odd_addr  = half[ODD_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_even_q  <= GATE_EVEN[even_addr];
            r_odd_q   <= GATE_ODD[odd_addr];
            r_odd_sel <= idx[0];
            r_sat     <= sat;
            r_frac    <= frac;
            r_env     <= i_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign lo     = (r_odd_sel && !r_sat) ? r_odd_q : r_even_q;
    assign hi     = r_odd_sel ? r_even_q : r_odd_q;
    assign delta  = (!r_sat && hi >= lo) ? hi - lo : '0;
    assign prod   = delta * r_frac;
    assign o_gate = lo + GATE_BITS'(prod >> FB);

    assign o_valid = r_valid;
    assign o_env   = r_env;

endmodule

// ===== src/attack_release_envelope_gate.sv =====
// Attack/release envelope follower with a tanh gate output.
// Input channel: one sample frame (left, right) per request on i_in_valid/o_in_ready.
// Output channel: envelope level and gate per frame on o_out_valid/i_out_ready,
// one result per accepted frame, in order.
// Config channel: i_cfg_valid with i_cfg_index/i_cfg_data; always ready. Index 0 is
// the attack coefficient, 1 the release coefficient, 2 the channel count; others
// are dropped. Write only while no frame is in flight.
// Pipeline: lane, merge, envelope, gate-table and output registers, in that order.
// Throughput: one frame per cycle while the skid register is empty; the envelope update
// (compare, one 17 x 25 multiply, add) feeds back combinationally into the envelope register.
// The tanh table lives in two banked ROMs with registered read data.
// Reset: envelope clears to zero, configuration registers return to their defaults, no
// result is pending.
// Stall: a skid register behind the output register takes one more result; the
// pipeline freezes and o_in_ready drops only while the skid register is full.
// Depends on areg_pkg, the defines header and the lane, merge, envelope and gate modules.
`include "attack_release_envelope_gate_defines.svh"

module attack_release_envelope_gate
    import areg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic        [SAMPLE_BITS-1:0] o_envelope_level,
    output logic        [GATE_BITS-1:0]   o_gate_level,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic        [COEF_BITS-1:0]   i_cfg_data
);

    localparam logic [SAMPLE_BITS-1:0] ENV_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    t_cfg                   r_cfg;
    logic                   en;
    logic                   r_a_valid;
    logic                   r_b_valid;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [SAMPLE_BITS-1:0] level;
    logic                   env_valid;
    logic [SAMPLE_BITS-1:0] env;
    logic                   g_valid;
    logic [SAMPLE_BITS-1:0] g_env;
    logic [GATE_BITS-1:0]   g_gate;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_env;
    logic [GATE_BITS-1:0]   r_out_gate;
    logic                   r_skid_valid;
    logic [SAMPLE_BITS-1:0] r_skid_env;
    logic [GATE_BITS-1:0]   r_skid_gate;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff  <= ATTACK_RST;
            r_cfg.release_coeff <= RELEASE_RST;
            r_cfg.channel_count <= CHAN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ATTACK:   r_cfg.attack_coeff  <= i_cfg_data;
                CFG_RELEASE:  r_cfg.release_coeff <= i_cfg_data;
                CFG_CHANNELS: r_cfg.channel_count <= i_cfg_data[CHAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // the whole pipeline advances unless the skid register holds a result
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
        end
    end

    areg_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sample (i_left_sample),
        .o_mag    (mag_l)
    );

    areg_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sample (i_right_sample),
        .o_mag    (mag_r)
    );

    areg_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_channel_count (r_cfg.channel_count),
        .i_mag_l         (mag_l),
        .i_mag_r         (mag_r),
        .o_level         (level)
    );

    areg_env #(.SAMPLE_BITS(SAMPLE_BITS)) u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_cfg   (r_cfg),
        .i_level (level),
        .o_valid (env_valid),
        .o_env   (env)
    );

    areg_gate #(.SAMPLE_BITS(SAMPLE_BITS)) u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (env_valid),
        .i_env   (env),
        .o_valid (g_valid),
        .o_env   (g_env),
        .o_gate  (g_gate)
    );

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en && g_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && g_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_env  <= g_env;
                r_skid_gate <= g_gate;
            end else begin
                r_out_env  <= g_env;
                r_out_gate <= g_gate;
            end
        end else if (i_out_ready && r_skid_valid) begin
            r_out_env  <= r_skid_env;
            r_out_gate <= r_skid_gate;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_envelope_level = r_out_env;
    assign o_gate_level     = r_out_gate;

    `AREG_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `AREG_ASSERT_IMP(a_skid_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && !i_out_ready), "skid filled without a stall")
    `AREG_ASSERT_IMP(a_env_range, i_clk, i_rst_n, o_out_valid, o_envelope_level <= ENV_MAX, "envelope out of range")
    `AREG_ASSERT_IMP(a_zero_gate, i_clk, i_rst_n, o_out_valid && (o_envelope_level == '0), o_gate_level == '0, "nonzero gate at zero envelope")

endmodule
